// ===== hw/rtl/ate_pkg.sv =====
// Shared types, constants and command codes of the alarm table engine.
package ate_pkg;

  localparam int unsigned MaxEntries = 16;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);
  localparam int unsigned IdW        = 32;
  localparam int unsigned SevW       = 2;
  localparam int unsigned RidxW      = 4;
  localparam int unsigned CmdW       = 3;
  localparam int unsigned StatW      = 2;
  localparam int unsigned InDataW    = 40;
  localparam int unsigned OutDataW   = 88;

  typedef enum logic [CmdW-1:0] {
    CmdInit   = 3'd0,
    CmdDeinit = 3'd1,
    CmdAdd    = 3'd2,
    CmdAck    = 3'd3,
    CmdCount  = 3'd4,
    CmdRead   = 3'd5
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    StOk       = 2'd0,
    StNotInit  = 2'd1,
    StFull     = 2'd2,
    StNotFound = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SScan,
    SUpdate,
    SRead,
    SDone
  } state_e;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [SevW-1:0] sev;
    logic            acked;
  } entry_t;

  typedef struct packed {
    status_e         status;
    logic            updated_event;
    logic [IdW-1:0]  event_id;
    logic            critical_alert;
    logic            audit_ack;
    logic [CntW-1:0] active_count;
    logic [CntW-1:0] entry_count;
    logic            entry_valid;
    logic [IdW-1:0]  entry_id;
    logic [SevW-1:0] entry_severity;
    logic            entry_acked;
  } result_t;

endpackage

// ===== hw/rtl/alarm_table_engine_core.sv =====
// Alarm table engine: keyed alarm table held in one synchronous memory.
//
// Each transfer on the slave side carries one command and yields exactly one result
// transfer on the master side. The table sits in one synchronous memory with one read
// per cycle, so add, ack and count walk the stored entries in order in SScan, then pass
// through SUpdate and SDone before the engine takes the next command. Read fetches only
// the indexed entry, through SRead and SDone; init, deinit, the unused codes and add or
// ack while disabled go straight to SDone. A finished result waits in an output
// register, and the next command is accepted meanwhile; the following result holds in
// SDone until the waiting one is taken.
// Init and deinit empty the table at once by resetting the fill count; no clearing pass.
module alarm_table_engine_core import ate_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SevW-1:0]     cfg_wdata_i,     // critical_severity
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [31:0] alarm_id, [33:32] severity_code, [37:34] read_index, [39:38] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic [CmdW-1:0]     s_axis_tuser,    // [2:0] cmd
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] updated_event, [32:1] event_id, [33] critical_alert, [34] audit_ack,
  // [39:35] active_count, [44:40] entry_count, [45] entry_valid, [77:46] entry_id,
  // [79:78] entry_severity, [80] entry_acked, [87:81] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic [StatW-1:0]    m_axis_tuser     // [1:0] status
);

  state_e            state_q, state_d;
  cmd_e              op_q, op_d;
  logic [IdW-1:0]    id_q, id_d;
  logic [SevW-1:0]   sev_q, sev_d;
  logic [RidxW-1:0]  ridx_q, ridx_d;
  logic [CntW-1:0]   used_q, used_d;
  logic              en_q, en_d;
  logic [SevW-1:0]   crit_q;
  logic [CntW-1:0]   scan_q, scan_d;
  logic [CntW-1:0]   act_q, act_d;
  logic              hit_q, hit_d;
  logic [IdxW-1:0]   hit_pos_q, hit_pos_d;
  entry_t            hit_ent_q, hit_ent_d;
  result_t           res_q, res_d;
  result_t           out_q, out_d;
  logic              out_vld_q, out_vld_d;

  entry_t            mem [MaxEntries];
  logic              mem_we, mem_re;
  logic [IdxW-1:0]   mem_waddr, mem_raddr;
  entry_t            mem_wdata;
  entry_t            rd_data_q;
  logic              rd_vld_q;
  logic [IdxW-1:0]   rd_pos_q;

  logic              in_xfer;
  cmd_e              in_cmd;
  logic [IdW-1:0]    in_id;
  logic [SevW-1:0]   in_sev;
  logic [RidxW-1:0]  in_ridx;

  assign s_axis_tready = (state_q == SIdle);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign in_cmd        = cmd_e'(s_axis_tuser);
  assign in_id         = s_axis_tdata[31:0];
  assign in_sev        = s_axis_tdata[33:32];
  assign in_ridx       = s_axis_tdata[37:34];

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      used_q    <= '0;
      en_q      <= 1'b0;
      crit_q    <= 2'd3;
      out_vld_q <= 1'b0;
      rd_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      en_q      <= en_d;
      out_vld_q <= out_vld_d;
      rd_vld_q  <= mem_re;
      hit_q     <= hit_d;
      if (cfg_we_i) begin
        crit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    id_q      <= id_d;
    sev_q     <= sev_d;
    ridx_q    <= ridx_d;
    scan_q    <= scan_d;
    act_q     <= act_d;
    hit_pos_q <= hit_pos_d;
    hit_ent_q <= hit_ent_d;
    res_q     <= res_d;
    out_q     <= out_d;
    rd_pos_q  <= mem_raddr;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: begin
        if (in_xfer) begin
          case (in_cmd)
            CmdAdd, CmdAck: state_d = en_q ? SScan : SDone;
            CmdCount:       state_d = SScan;
            CmdRead:        state_d = SRead;
            default:        state_d = SDone;
          endcase
        end
      end
      SScan: begin
        // leave once every entry is issued and the last read has been compared
        if (scan_q >= used_q && !rd_vld_q) begin
          state_d = SUpdate;
        end
      end
      SUpdate: state_d = SDone;
      SRead:   state_d = SDone;
      SDone: begin
        if (!out_vld_q || m_axis_tready) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_d      = op_q;
    id_d      = id_q;
    sev_d     = sev_q;
    ridx_d    = ridx_q;
    used_d    = used_q;
    en_d      = en_q;
    scan_d    = scan_q;
    act_d     = act_q;
    hit_d     = hit_q;
    hit_pos_d = hit_pos_q;
    hit_ent_d = hit_ent_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = hit_pos_q;
    mem_raddr = scan_q[IdxW-1:0];
    mem_wdata = hit_ent_q;

    case (state_q)
      SIdle: begin
        if (in_xfer) begin
          op_d   = in_cmd;
          id_d   = in_id;
          sev_d  = in_sev;
          ridx_d = in_ridx;
          scan_d = '0;
          act_d  = '0;
          hit_d  = 1'b0;
          res_d  = '0;
          // start the entry read now so the data is ready in SRead
          mem_raddr = in_ridx[IdxW-1:0];
          mem_re    = (in_cmd == CmdRead);
          case (in_cmd)
            CmdInit: begin
              used_d = '0;
              en_d   = 1'b1;
            end
            CmdDeinit: begin
              used_d = '0;
              en_d   = 1'b0;
            end
            CmdAdd, CmdAck: begin
              if (!en_q) begin
                res_d.status = StNotInit;
              end
            end
            default: ;
          endcase
          res_d.entry_count = used_d;
        end
      end
      SScan: begin
        if (scan_q < used_q) begin
          mem_re = 1'b1;
          scan_d = scan_q + CntW'(1);
        end
        if (rd_vld_q) begin
          if (rd_data_q.id == id_q) begin
            hit_d     = 1'b1;
            hit_pos_d = rd_pos_q;
            hit_ent_d = rd_data_q;
          end
          if (!rd_data_q.acked && rd_data_q.sev == sev_q) begin
            act_d = act_q + CntW'(1);
          end
        end
      end
      SUpdate: begin
        case (op_q)
          CmdAdd: begin
            if (hit_q) begin
              // keep the ack flag, replace severity
              mem_we    = 1'b1;
              mem_wdata = '{id: id_q, sev: sev_q, acked: hit_ent_q.acked};
              res_d.updated_event = 1'b1;
              res_d.event_id      = id_q;
            end else if (used_q >= CntW'(MaxEntries)) begin
              res_d.status = StFull;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = used_q[IdxW-1:0];
              mem_wdata = '{id: id_q, sev: sev_q, acked: 1'b0};
              used_d    = used_q + CntW'(1);
              res_d.updated_event  = 1'b1;
              res_d.event_id       = id_q;
              res_d.critical_alert = (sev_q == crit_q);
            end
          end
          CmdAck: begin
            if (hit_q) begin
              mem_we    = 1'b1;
              mem_wdata = '{id: hit_ent_q.id, sev: hit_ent_q.sev, acked: 1'b1};
              res_d.updated_event = 1'b1;
              res_d.event_id      = id_q;
              res_d.audit_ack     = 1'b1;
            end else begin
              res_d.status = StNotFound;
            end
          end
          CmdCount: res_d.active_count = act_q;
          default: ;
        endcase
        res_d.entry_count = used_d;
      end
      SRead: begin
        if (CntW'(ridx_q) < used_q) begin
          res_d.entry_valid    = 1'b1;
          res_d.entry_id       = rd_data_q.id;
          res_d.entry_severity = rd_data_q.sev;
          res_d.entry_acked    = rd_data_q.acked;
        end
      end
      SDone: begin
        if (!out_vld_q || m_axis_tready) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {7'd0, out_q.entry_acked, out_q.entry_severity, out_q.entry_id,
                          out_q.entry_valid, out_q.entry_count, out_q.active_count,
                          out_q.audit_ack, out_q.critical_alert, out_q.event_id,
                          out_q.updated_event};

endmodule

// ===== hw/rtl/ate_checker.sv =====
// Port-level checks of the alarm table engine, bound to alarm_table_engine_core.
module ate_checker import ate_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [StatW-1:0]    m_axis_tuser
);

  // a held result must not change until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one command at a time: no transfer right after a transfer
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a command is in work");

  // an error status carries no event, alert or audit pulse
  a_err_no_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != StOk |->
      !m_axis_tdata[0] && !m_axis_tdata[33] && !m_axis_tdata[34])
    else $error("pulse on failed command");

  // counts stay in range and unused fields are zero
  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      m_axis_tdata[44:40] <= CntW'(MaxEntries) &&
      m_axis_tdata[39:35] <= m_axis_tdata[44:40] &&
      (m_axis_tdata[0] || m_axis_tdata[32:1] == 32'd0) &&
      (m_axis_tdata[45] || m_axis_tdata[80:46] == 35'd0))
    else $error("result fields inconsistent");

endmodule

bind alarm_table_engine_core ate_checker u_ate_checker (.*);

// ===== bench/tb_top.sv =====
// Self-checking bench for alarm_table_engine_core: command streams checked against a shadow table.
`timescale 1ns / 100ps

module tb_top import ate_pkg::*;;

  localparam logic [CmdW-1:0] CmdRsvd6 = 3'd6;
  localparam logic [CmdW-1:0] CmdRsvd7 = 3'd7;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned PhaseItems  = 200;

  typedef struct packed {
    logic [CmdW-1:0]  op;
    logic [IdW-1:0]   id;
    logic [SevW-1:0]  sev;
    logic [RidxW-1:0] ridx;
  } alarm_cmd_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [SevW-1:0]     cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [CmdW-1:0]     s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [StatW-1:0]    m_axis_tuser;

  // shadow copy of the alarm table
  logic [IdW-1:0]  shadow_ids   [MaxEntries];
  logic [SevW-1:0] shadow_sev   [MaxEntries];
  logic            shadow_acked [MaxEntries];
  int unsigned     shadow_used    = 0;
  logic            shadow_enabled = 1'b0;
  logic [SevW-1:0] shadow_crit    = 2'd3;

  alarm_cmd_t  cmd_queue [$];
  result_t     due_results [$];
  int unsigned n_queued     = 0;
  int unsigned n_accepted   = 0;
  int unsigned n_checked    = 0;
  int unsigned n_cfg_writes = 0;
  int unsigned n_alerts     = 0;
  int unsigned n_full       = 0;
  int unsigned n_not_found  = 0;
  int unsigned err_count    = 0;
  int unsigned tx_gap       = 0;
  int unsigned rx_hold      = 0;
  int unsigned idle_cycles  = 0;
  logic [31:0] cycle_cnt    = '0;

  alarm_table_engine_core u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  always #10 clk_i = ~clk_i;

  // Mostly short idles, a few long ones; one quarter of the time none at all.
  function automatic int unsigned pick_idle();
    int unsigned r;
    if (cycle_cnt[9:8] == 2'b11) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic result_t apply_alarm_cmd(alarm_cmd_t c);
    result_t     r;
    int unsigned pos;
    int unsigned n;
    int unsigned i;
    r   = '0;
    pos = MaxEntries;
    for (i = 0; i < shadow_used; i++) begin
      if (pos == MaxEntries && shadow_ids[i] == c.id) pos = i;
    end
    case (c.op)
      CmdInit: begin
        shadow_used    = 0;
        shadow_enabled = 1'b1;
      end
      CmdDeinit: begin
        shadow_used    = 0;
        shadow_enabled = 1'b0;
      end
      CmdAdd: begin
        if (!shadow_enabled) begin
          r.status = StNotInit;
        end else if (pos < MaxEntries) begin
          // hit: new severity, ack flag kept, never an alert
          shadow_sev[pos] = c.sev;
          r.updated_event = 1'b1;
          r.event_id      = c.id;
        end else if (shadow_used >= MaxEntries) begin
          r.status = StFull;
          n_full++;
        end else begin
          shadow_ids[shadow_used]   = c.id;
          shadow_sev[shadow_used]   = c.sev;
          shadow_acked[shadow_used] = 1'b0;
          shadow_used++;
          r.critical_alert = (c.sev == shadow_crit);
          if (r.critical_alert) n_alerts++;
          r.updated_event = 1'b1;
          r.event_id      = c.id;
        end
      end
      CmdAck: begin
        if (!shadow_enabled) begin
          r.status = StNotInit;
        end else if (pos >= MaxEntries) begin
          r.status = StNotFound;
          n_not_found++;
        end else begin
          shadow_acked[pos] = 1'b1;
          r.updated_event   = 1'b1;
          r.event_id        = c.id;
          r.audit_ack       = 1'b1;
        end
      end
      CmdCount: begin
        n = 0;
        for (i = 0; i < shadow_used; i++) begin
          if (!shadow_acked[i] && shadow_sev[i] == c.sev) n++;
        end
        r.active_count = CntW'(n);
      end
      CmdRead: begin
        if (c.ridx < shadow_used) begin
          r.entry_valid    = 1'b1;
          r.entry_id       = shadow_ids[c.ridx];
          r.entry_severity = shadow_sev[c.ridx];
          r.entry_acked    = shadow_acked[c.ridx];
        end
      end
      default: ;
    endcase
    r.entry_count = CntW'(shadow_used);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_count++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  task automatic queue_cmd(logic [CmdW-1:0] op, logic [IdW-1:0] id, logic [SevW-1:0] sev,
                           logic [RidxW-1:0] ridx);
    alarm_cmd_t c;
    c.op   = op;
    c.id   = id;
    c.sev  = sev;
    c.ridx = ridx;
    cmd_queue.push_back(c);
    n_queued++;
  endtask

  // Well-formed run: init when start_enabled, then traffic on a small id pool so hits, acks and full tables occur.
  task automatic queue_session(int unsigned len, bit start_enabled);
    logic [IdW-1:0] pool [$];
    int unsigned    pool_n;
    int unsigned    r;
    logic [IdW-1:0] id;
    pool_n = $urandom_range(3, 24);
    repeat (pool_n) pool.push_back($urandom);
    if (start_enabled) queue_cmd(CmdInit, $urandom, SevW'($urandom), RidxW'($urandom));
    repeat (len) begin
      r  = $urandom_range(0, 99);
      id = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, pool_n - 1)];
      if (r < 45)      queue_cmd(CmdAdd, id, SevW'($urandom), RidxW'($urandom));
      else if (r < 65) queue_cmd(CmdAck, id, SevW'($urandom), RidxW'($urandom));
      else if (r < 77) queue_cmd(CmdCount, $urandom, SevW'($urandom), RidxW'($urandom));
      else if (r < 90) queue_cmd(CmdRead, $urandom, SevW'($urandom),
                                 RidxW'($urandom_range(0, 15)));
      else if (r < 93) queue_cmd(CmdDeinit, $urandom, SevW'($urandom), RidxW'($urandom));
      else if (r < 95) queue_cmd(CmdInit, $urandom, SevW'($urandom), RidxW'($urandom));
      else if (r < 98) queue_cmd($urandom_range(0, 1) ? CmdRsvd6 : CmdRsvd7,
                                 $urandom, SevW'($urandom), RidxW'($urandom));
      else             queue_cmd(CmdAdd, $urandom, SevW'($urandom), RidxW'($urandom));
    end
  endtask

  // Hold until every command is taken and answered, then let the engine settle.
  task automatic wait_drained();
    while (n_accepted != n_queued || due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_critical(logic [SevW-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    shadow_crit  = v;
    n_cfg_writes++;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_cmds
    alarm_cmd_t nxt;
    alarm_cmd_t seen;
    logic       take;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      tx_gap         = 0;
    end else begin
      take = s_axis_tvalid && s_axis_tready;
      if (take) begin
        seen.op   = s_axis_tuser;
        seen.id   = s_axis_tdata[IdW-1:0];
        seen.sev  = s_axis_tdata[IdW+SevW-1:IdW];
        seen.ridx = s_axis_tdata[IdW+SevW+RidxW-1:IdW+SevW];
        due_results.push_back(apply_alarm_cmd(seen));
        n_accepted++;
      end
      if (!s_axis_tvalid || take) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          nxt = cmd_queue.pop_front();
          s_axis_tdata  <= {2'b00, nxt.ridx, nxt.sev, nxt.id};
          s_axis_tuser  <= nxt.op;
          s_axis_tvalid <= 1'b1;
          tx_gap         = pick_idle();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch_results
    result_t got;
    result_t want;
    logic    xfer;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_hold        = 0;
    end else begin
      xfer = m_axis_tvalid && m_axis_tready;
      if (xfer) begin
        got.status         = status_e'(m_axis_tuser);
        got.updated_event  = m_axis_tdata[0];
        got.event_id       = m_axis_tdata[32:1];
        got.critical_alert = m_axis_tdata[33];
        got.audit_ack      = m_axis_tdata[34];
        got.active_count   = m_axis_tdata[39:35];
        got.entry_count    = m_axis_tdata[44:40];
        got.entry_valid    = m_axis_tdata[45];
        got.entry_id       = m_axis_tdata[77:46];
        got.entry_severity = m_axis_tdata[79:78];
        got.entry_acked    = m_axis_tdata[80];
        if (due_results.size() == 0) begin
          err_count++;
          $error("result transfer with no command outstanding");
        end else begin
          want = due_results.pop_front();
          n_checked++;
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("updated_event", 32'(want.updated_event), 32'(got.updated_event));
          check_field("event_id", want.event_id, got.event_id);
          check_field("critical_alert", 32'(want.critical_alert), 32'(got.critical_alert));
          check_field("audit_ack", 32'(want.audit_ack), 32'(got.audit_ack));
          check_field("active_count", 32'(want.active_count), 32'(got.active_count));
          check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
          check_field("entry_valid", 32'(want.entry_valid), 32'(got.entry_valid));
          check_field("entry_id", want.entry_id, got.entry_id);
          check_field("entry_severity", 32'(want.entry_severity), 32'(got.entry_severity));
          check_field("entry_acked", 32'(want.entry_acked), 32'(got.entry_acked));
        end
      end
      // stall after some transfers and now and then while waiting
      if (rx_hold > 0) rx_hold--;
      else if (xfer || $urandom_range(0, 31) == 0) rx_hold = pick_idle();
      m_axis_tready <= (rx_hold == 0);
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("tb_top: timeout, no transfer for %0d cycles", IdleLimit);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic [SevW-1:0] crit_plan [6];
    int unsigned     target;
    crit_plan = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd0, 2'd3};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_critical(2'd3);

    // disabled engine: add and ack refused, count and read served
    queue_cmd(CmdAdd, 32'hFFFF_FFFF, 2'd3, 4'hF);
    queue_cmd(CmdAck, 32'h0000_0000, 2'd0, 4'h0);
    queue_cmd(CmdCount, 32'h0, 2'd3, 4'h0);
    queue_cmd(CmdRead, 32'h0, 2'd0, 4'h0);
    queue_cmd(CmdInit, 32'h0, 2'd0, 4'h0);
    queue_cmd(CmdAdd, 32'h0000_0000, 2'd3, 4'h0);
    queue_cmd(CmdAdd, 32'hFFFF_FFFF, 2'd0, 4'hF);
    queue_cmd(CmdAdd, 32'h0000_0000, 2'd1, 4'h0);
    // re-adding at critical severity must stay quiet
    queue_cmd(CmdAdd, 32'hFFFF_FFFF, 2'd3, 4'h0);
    queue_cmd(CmdAck, 32'h0000_0000, 2'd0, 4'h0);
    queue_cmd(CmdAdd, 32'h0000_0000, 2'd2, 4'h0);
    queue_cmd(CmdAck, 32'h8000_0001, 2'd0, 4'h0);
    queue_cmd(CmdCount, 32'h0, 2'd3, 4'h0);
    queue_cmd(CmdCount, 32'h0, 2'd2, 4'h0);
    queue_cmd(CmdRead, 32'h0, 2'd0, 4'h0);
    queue_cmd(CmdRead, 32'h0, 2'd0, 4'h1);
    queue_cmd(CmdRead, 32'h0, 2'd0, 4'h2);
    queue_cmd(CmdRead, 32'h0, 2'd0, 4'hF);
    queue_cmd(CmdRsvd6, 32'hFFFF_FFFF, 2'd3, 4'hF);
    queue_cmd(CmdRsvd7, 32'h0, 2'd0, 4'h0);
    queue_cmd(CmdDeinit, 32'h0, 2'd0, 4'h0);
    queue_cmd(CmdCount, 32'h0, 2'd0, 4'h0);
    queue_cmd(CmdRead, 32'h0, 2'd0, 4'h0);
    queue_cmd(CmdAdd, 32'h1234_5678, 2'd1, 4'h0);
    wait_drained();

    foreach (crit_plan[p]) begin
      set_critical(crit_plan[p]);
      target = n_queued + PhaseItems;
      while (n_queued < target) queue_session($urandom_range(8, 70), $urandom_range(0, 9) != 0);
      wait_drained();
    end

    $display("tb_top: %0d commands checked over %0d critical-severity settings",
             n_checked, n_cfg_writes);
    $display("tb_top: %0d critical alerts, %0d full-table rejects, %0d unknown-id acks",
             n_alerts, n_full, n_not_found);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
